// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/irg_pkg.sv -----
// Shared types, codes and constants of the ISAAC random generator.
`timescale 1ns / 1ps
`default_nettype none
package irg_pkg;

  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  // Request codes.
  localparam logic [1:0] REQ_SEED    = 2'd0;
  localparam logic [1:0] REQ_INIT    = 2'd1;
  localparam logic [1:0] REQ_DRAW    = 2'd2;
  localparam logic [1:0] REQ_BOUNDED = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  seed_index;
    logic [31:0] seed_word;
    logic [10:0] seed_length;
    logic [31:0] bound;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        value_valid;
    logic        seeded;
  } result_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_SEED,
    OP_KS_INIT,
    OP_SCR,
    OP_KS_RD,
    OP_KS_ADD,
    OP_KS_WR,
    OP_GEN_BEGIN,
    OP_GEN_X,
    OP_GEN_H,
    OP_GEN_Y,
    OP_GEN_W,
    OP_GEN_B,
    OP_GEN_R,
    OP_POS_FULL,
    OP_DRAW_RD,
    OP_DRAW_GET,
    OP_RMIN_GO,
    OP_RMIN_WAIT,
    OP_REM_GO,
    OP_REM_WAIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] idx;
    logic       pass;
  } cmd_t;

  typedef struct packed {
    logic pos_empty;
    logic reject;
    logic small_bound;
    logic div_done;
  } sts_t;

  // Shift of one scramble line: even lines shift left, odd lines right.
  function automatic logic [31:0] scr_shift(input logic [2:0] step, input logic [31:0] w);
    logic [31:0] s;
    s = w;
    unique case (step)
      3'd0: s = w << 11;
      3'd1: s = w >> 2;
      3'd2: s = w << 8;
      3'd3: s = w >> 16;
      3'd4: s = w << 10;
      3'd5: s = w >> 4;
      3'd6: s = w << 8;
      3'd7: s = w >> 9;
      default: s = w;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- design/irg_div.sv -----
// Bit-serial remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module irg_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      rem
);
  logic        active;
  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [32:0] shifted;
  logic [33:0] diff;

  // Shift in the next dividend bit and try a subtraction.
  assign shifted = {rem, quo[31]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and dividend shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (active) begin
      quo <= {quo[30:0], 1'b0};
      rem <= diff[33] ? shifted[31:0] : diff[31:0];
    end
  end
endmodule
`default_nettype wire

// ----- design/irg_datapath.sv -----
// Datapath: state memories, mixer registers, generator arithmetic and result.
`timescale 1ns / 1ps
`default_nettype none
module irg_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire irg_pkg::cmd_t   cmd,
  input  wire irg_pkg::item_t  item,
  output irg_pkg::sts_t        sts,
  output irg_pkg::result_t     result
);
  import irg_pkg::*;

  logic [31:0] m_mem [256];
  logic [31:0] r_mem [256];
  logic [31:0] m_rd, r_rd;
  logic [7:0]  m_ra, m_wa, r_ra, r_wa;
  logic [31:0] m_wd, r_wd;
  logic        m_we, r_we;

  item_t       item_q;
  logic [31:0] acc_a, last_b, cnt_c;
  logic [8:0]  pos;
  logic        seed_good, zero_seed;
  logic [31:0] v [8];
  logic [31:0] v_scr [8];
  logic [31:0] x, y, word, rmin, value;
  logic        valid;
  logic [31:0] mix, y_new, ks_src;
  logic [2:0]  k0, k1, k2, k3;
  logic [31:0] nvk;
  logic        div_start, div_done;
  logic [31:0] div_dividend, div_rem;

  // Mixer update of the accumulator, chosen by word position.
  always_comb begin
    unique case (cmd.idx[1:0])
      2'd0: mix = acc_a ^ (acc_a << 13);
      2'd1: mix = acc_a ^ (acc_a >> 6);
      2'd2: mix = acc_a ^ (acc_a << 2);
      default: mix = acc_a ^ (acc_a >> 16);
    endcase
  end

  assign y_new  = m_rd + acc_a + last_b;
  assign ks_src = cmd.pass ? m_rd : (zero_seed ? 32'd0 : r_rd);

  // One line of the golden-ratio scramble.
  always_comb begin
    k0  = cmd.idx[2:0];
    k1  = k0 + 3'd1;
    k2  = k0 + 3'd2;
    k3  = k0 + 3'd3;
    nvk = v[k0] ^ scr_shift(k0, v[k1]);
    for (int n = 0; n < 8; n++) v_scr[n] = v[n];
    v_scr[k0] = nvk;
    v_scr[k3] = v[k3] + nvk;
    v_scr[k1] = v[k1] + v[k2];
  end

  // Memory address and write selection.
  always_comb begin
    m_ra = cmd.idx;
    m_we = 1'b0;
    m_wa = cmd.idx;
    m_wd = '0;
    r_ra = cmd.idx;
    r_we = 1'b0;
    r_wa = cmd.idx;
    r_wd = '0;
    unique case (cmd.op)
      OP_CLEAR: begin
        m_we = 1'b1;
        r_we = 1'b1;
      end
      OP_SEED: begin
        r_we = 1'b1;
        r_wa = item_q.seed_index;
        r_wd = item_q.seed_word;
      end
      OP_KS_WR: begin
        m_we = 1'b1;
        m_wd = v[cmd.idx[2:0]];
      end
      OP_GEN_H: m_ra = cmd.idx + 8'd128;
      OP_GEN_Y: m_ra = x[9:2];
      OP_GEN_W: begin
        m_we = 1'b1;
        m_wd = y_new;
      end
      OP_GEN_B: m_ra = y[17:10];
      OP_GEN_R: begin
        r_we = 1'b1;
        r_wd = m_rd + x;
      end
      OP_DRAW_RD: r_ra = pos[7:0];
      default: ;
    endcase
  end

  // Mix memory and result memory, one read and one write port each, registered read.
  always_ff @(posedge clk) begin
    if (m_we) m_mem[m_wa] <= m_wd;
    m_rd <= m_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (r_we) r_mem[r_wa] <= r_wd;
    r_rd <= r_mem[r_ra];
  end

  // Generator state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_a     <= '0;
      last_b    <= '0;
      cnt_c     <= '0;
      pos       <= '0;
      seed_good <= 1'b0;
      zero_seed <= 1'b0;
      valid     <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_ACCEPT: valid <= (item.req_type == REQ_DRAW) || (item.req_type == REQ_BOUNDED);
        OP_KS_INIT: begin
          acc_a     <= '0;
          last_b    <= '0;
          cnt_c     <= '0;
          zero_seed <= (item_q.seed_length == 11'd0);
          seed_good <= (item_q.seed_length >= 11'd16);
        end
        OP_GEN_BEGIN: begin
          cnt_c  <= cnt_c + 32'd1;
          last_b <= last_b + cnt_c + 32'd1;
          pos    <= '0;
        end
        OP_GEN_Y: acc_a <= m_rd + mix;
        OP_GEN_R: last_b <= m_rd + x;
        OP_POS_FULL: pos <= 9'd256;
        OP_DRAW_RD: pos <= pos + 9'd1;
        default: ;
      endcase
    end
  end

  // Payload registers of the key schedule, generator and result.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        item_q <= item;
        value  <= '0;
      end
      OP_KS_INIT: for (int n = 0; n < 8; n++) v[n] <= GOLDEN;
      OP_SCR: for (int n = 0; n < 8; n++) v[n] <= v_scr[n];
      OP_KS_ADD: v[cmd.idx[2:0]] <= v[cmd.idx[2:0]] + ks_src;
      OP_GEN_H: x <= m_rd;
      OP_GEN_W: y <= y_new;
      OP_DRAW_GET: begin
        word <= r_rd;
        if (item_q.req_type == REQ_DRAW) value <= r_rd;
      end
      OP_RMIN_WAIT: if (div_done) rmin <= div_rem;
      OP_REM_WAIT: if (div_done) value <= div_rem;
      default: ;
    endcase
  end

  // Shared remainder unit for the rejection limit and the final reduction.
  assign div_start    = (cmd.op == OP_RMIN_GO) || (cmd.op == OP_REM_GO);
  assign div_dividend = (cmd.op == OP_RMIN_GO) ? (32'd0 - item_q.bound) : word;

  irg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (item_q.bound),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Status back to the controller and the result transfer.
  assign sts.pos_empty   = pos[8];
  assign sts.reject      = (r_rd < rmin);
  assign sts.small_bound = (item_q.bound[31:1] == 31'd0);
  assign sts.div_done    = div_done;

  assign result.value       = value;
  assign result.value_valid = valid;
  assign result.seeded      = seed_good;
endmodule
`default_nettype wire

// ----- design/irg_ctrl.sv -----
// Controller: sequences clearing, key schedule, generation and draws.
`timescale 1ns / 1ps
`default_nettype none
module irg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    req_type,
  input  wire irg_pkg::sts_t sts,
  output irg_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               done
);
  import irg_pkg::*;

  typedef enum logic [24:0] {
    S_CLEAR     = 25'd1 << 0,
    S_IDLE      = 25'd1 << 1,
    S_SEED      = 25'd1 << 2,
    S_KS_INIT   = 25'd1 << 3,
    S_KS_GOLD   = 25'd1 << 4,
    S_KS_RD     = 25'd1 << 5,
    S_KS_ADD    = 25'd1 << 6,
    S_KS_SCR    = 25'd1 << 7,
    S_KS_WR     = 25'd1 << 8,
    S_GEN_BEGIN = 25'd1 << 9,
    S_GEN_X     = 25'd1 << 10,
    S_GEN_H     = 25'd1 << 11,
    S_GEN_Y     = 25'd1 << 12,
    S_GEN_W     = 25'd1 << 13,
    S_GEN_B     = 25'd1 << 14,
    S_GEN_R     = 25'd1 << 15,
    S_KS_END    = 25'd1 << 16,
    S_DRAW      = 25'd1 << 17,
    S_DRAW_GET  = 25'd1 << 18,
    S_RMIN_GO   = 25'd1 << 19,
    S_RMIN_WAIT = 25'd1 << 20,
    S_REM_GO    = 25'd1 << 21,
    S_REM_WAIT  = 25'd1 << 22,
    S_DONE      = 25'd1 << 23,
    S_SPARE     = 25'd1 << 24
  } state_t;

  state_t      state, state_next;
  logic [7:0]  word_idx;
  logic [4:0]  step;
  logic [4:0]  blk;
  logic        pass;
  logic        from_init;
  logic [1:0]  req;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (word_idx == 8'd255) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_SEED: state_next = S_SEED;
            REQ_INIT: state_next = S_KS_INIT;
            REQ_DRAW: state_next = S_DRAW;
            default:  state_next = S_RMIN_GO;
          endcase
        end
      end
      S_SEED:    state_next = S_DONE;
      S_KS_INIT: state_next = S_KS_GOLD;
      S_KS_GOLD: if (step == 5'd31) state_next = S_KS_RD;
      S_KS_RD:   state_next = S_KS_ADD;
      S_KS_ADD:  state_next = (step[2:0] == 3'd7) ? S_KS_SCR : S_KS_RD;
      S_KS_SCR:  if (step[2:0] == 3'd7) state_next = S_KS_WR;
      S_KS_WR: begin
        if (step[2:0] == 3'd7) begin
          state_next = (pass && blk == 5'd31) ? S_GEN_BEGIN : S_KS_RD;
        end
      end
      S_GEN_BEGIN: state_next = S_GEN_X;
      S_GEN_X:     state_next = S_GEN_H;
      S_GEN_H:     state_next = S_GEN_Y;
      S_GEN_Y:     state_next = S_GEN_W;
      S_GEN_W:     state_next = S_GEN_B;
      S_GEN_B:     state_next = S_GEN_R;
      S_GEN_R: begin
        if (word_idx == 8'd255) state_next = from_init ? S_KS_END : S_DRAW;
        else state_next = S_GEN_X;
      end
      S_KS_END: state_next = S_DONE;
      S_DRAW:   state_next = sts.pos_empty ? S_GEN_BEGIN : S_DRAW_GET;
      S_DRAW_GET: begin
        if (req == REQ_DRAW) state_next = S_DONE;
        else if (sts.reject) state_next = S_DRAW;
        else state_next = S_REM_GO;
      end
      S_RMIN_GO:   state_next = sts.small_bound ? S_DONE : S_RMIN_WAIT;
      S_RMIN_WAIT: if (sts.div_done) state_next = S_DRAW;
      S_REM_GO:    state_next = S_REM_WAIT;
      S_REM_WAIT:  if (sts.div_done) state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // State and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      word_idx  <= '0;
      step      <= '0;
      blk       <= '0;
      pass      <= 1'b0;
      from_init <= 1'b0;
      req       <= REQ_SEED;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: word_idx <= word_idx + 8'd1;
        S_IDLE: begin
          if (start) begin
            req       <= req_type;
            from_init <= 1'b0;
          end
        end
        S_KS_INIT: begin
          step      <= '0;
          blk       <= '0;
          pass      <= 1'b0;
          from_init <= 1'b1;
        end
        S_KS_GOLD: step <= step + 5'd1;
        S_KS_ADD, S_KS_SCR: step <= (step[2:0] == 3'd7) ? 5'd0 : step + 5'd1;
        S_KS_WR: begin
          step <= (step[2:0] == 3'd7) ? 5'd0 : step + 5'd1;
          if (step[2:0] == 3'd7) begin
            blk <= blk + 5'd1;
            if (blk == 5'd31) pass <= 1'b1;
          end
        end
        S_GEN_BEGIN: word_idx <= '0;
        S_GEN_R:     word_idx <= word_idx + 8'd1;
        default: ;
      endcase
    end
  end

  // Command to the datapath.
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.idx  = word_idx;
    cmd.pass = pass;
    unique case (state)
      S_CLEAR:     cmd.op = OP_CLEAR;
      S_IDLE:      if (start) cmd.op = OP_ACCEPT;
      S_SEED:      cmd.op = OP_SEED;
      S_KS_INIT:   cmd.op = OP_KS_INIT;
      S_KS_GOLD: begin
        cmd.op  = OP_SCR;
        cmd.idx = {5'd0, step[2:0]};
      end
      S_KS_RD: begin
        cmd.op  = OP_KS_RD;
        cmd.idx = {blk, step[2:0]};
      end
      S_KS_ADD: begin
        cmd.op  = OP_KS_ADD;
        cmd.idx = {blk, step[2:0]};
      end
      S_KS_SCR: begin
        cmd.op  = OP_SCR;
        cmd.idx = {5'd0, step[2:0]};
      end
      S_KS_WR: begin
        cmd.op  = OP_KS_WR;
        cmd.idx = {blk, step[2:0]};
      end
      S_GEN_BEGIN: cmd.op = OP_GEN_BEGIN;
      S_GEN_X:     cmd.op = OP_GEN_X;
      S_GEN_H:     cmd.op = OP_GEN_H;
      S_GEN_Y:     cmd.op = OP_GEN_Y;
      S_GEN_W:     cmd.op = OP_GEN_W;
      S_GEN_B:     cmd.op = OP_GEN_B;
      S_GEN_R:     cmd.op = OP_GEN_R;
      S_KS_END:    cmd.op = OP_POS_FULL;
      S_DRAW:      if (!sts.pos_empty) cmd.op = OP_DRAW_RD;
      S_DRAW_GET:  cmd.op = OP_DRAW_GET;
      S_RMIN_GO:   if (!sts.small_bound) cmd.op = OP_RMIN_GO;
      S_RMIN_WAIT: cmd.op = OP_RMIN_WAIT;
      S_REM_GO:    cmd.op = OP_REM_GO;
      S_REM_WAIT:  cmd.op = OP_REM_WAIT;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
endmodule
`default_nettype wire

// ----- design/isaac_random_generator.sv -----
// Top level of the ISAAC random generator: controller plus datapath.
// A seed write runs through S_SEED and S_DONE, a draw through S_DRAW, S_DRAW_GET and S_DONE; a
// draw on an exhausted store first regenerates all 256 words, and bounded draws with a bound above
// 1 run the remainder unit twice. Init runs 32 mixer steps, two passes over the store in blocks of
// 8 words and one generation round. Generation is paced by the single read port of the mix memory,
// read four times per generated word. Synchronous reset clears both memories while busy stays high.
`timescale 1ns / 1ps
`default_nettype none
module isaac_random_generator (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire irg_pkg::item_t   item,
  output logic                  busy,
  output logic                  done,
  output irg_pkg::result_t      result
);
  import irg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  irg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (item.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  irg_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .sts    (sts),
    .result (result)
  );
endmodule
`default_nettype wire

// ----- design/irg_checker.sv -----
// Port-level checker of the ISAAC random generator and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module irg_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire irg_pkg::result_t result
);
  import irg_pkg::*;

  // A result transfer happens only while an item is in work.
  `ASSERT_IMPL(a_done_busy, clk, rst, done, busy)
  // Each item gives one result strobe of a single cycle.
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // An accepted item makes the block busy.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // The clearing pass after reset holds the block busy.
  `ASSERT_NEXT(a_reset_busy, clk, 1'b0, rst, busy)
  // Items that are not draws return a zero value.
  `ASSERT_IMPL(a_nondraw_zero, clk, rst, done && !result.value_valid, result.value == 32'd0)
endmodule

bind isaac_random_generator irg_checker u_irg_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the ISAAC random generator with its own ISAAC predictor.
`timescale 1ns / 1ps
`default_nettype none

// Tracks generator state and holds the results still to arrive.
class isaac_scoreboard;
  bit [31:0] mix_mem[256];
  bit [31:0] out_words[256];
  bit [31:0] acc_a;
  bit [31:0] prev_b;
  bit [31:0] round_c;
  bit [8:0]  out_pos;
  bit        seed_ok;
  bit [31:0] mixer[8];
  irg_pkg::result_t pending_results[$];
  int errors;

  function new();
    foreach (mix_mem[i]) begin
      mix_mem[i] = '0;
      out_words[i] = '0;
    end
    acc_a = '0;
    prev_b = '0;
    round_c = '0;
    out_pos = '0;
    seed_ok = 1'b0;
    errors = 0;
  endfunction

  // One generation round refills all 256 output words.
  function void refill();
    bit [31:0] x;
    bit [31:0] y;
    round_c += 1;
    prev_b += round_c;
    for (int i = 0; i < 256; i++) begin
      x = mix_mem[i];
      case (i % 4)
        0: acc_a ^= acc_a << 13;
        1: acc_a ^= acc_a >> 6;
        2: acc_a ^= acc_a << 2;
        default: acc_a ^= acc_a >> 16;
      endcase
      acc_a = mix_mem[(i + 128) % 256] + acc_a;
      y = mix_mem[x[9:2]] + acc_a + prev_b;
      mix_mem[i] = y;
      prev_b = mix_mem[y[17:10]] + x;
      out_words[i] = prev_b;
    end
    out_pos = '0;
  endfunction

  function void churn();
    mixer[0] ^= mixer[1] << 11; mixer[3] += mixer[0]; mixer[1] += mixer[2];
    mixer[1] ^= mixer[2] >> 2;  mixer[4] += mixer[1]; mixer[2] += mixer[3];
    mixer[2] ^= mixer[3] << 8;  mixer[5] += mixer[2]; mixer[3] += mixer[4];
    mixer[3] ^= mixer[4] >> 16; mixer[6] += mixer[3]; mixer[4] += mixer[5];
    mixer[4] ^= mixer[5] << 10; mixer[7] += mixer[4]; mixer[5] += mixer[6];
    mixer[5] ^= mixer[6] >> 4;  mixer[0] += mixer[5]; mixer[6] += mixer[7];
    mixer[6] ^= mixer[7] << 8;  mixer[1] += mixer[6]; mixer[7] += mixer[0];
    mixer[7] ^= mixer[0] >> 9;  mixer[2] += mixer[7]; mixer[0] += mixer[1];
  endfunction

  // Key schedule: two folding passes, then one round; store left exhausted.
  function void seed_state(bit [10:0] len);
    foreach (mix_mem[i]) mix_mem[i] = '0;
    if (len == 0) begin
      foreach (out_words[i]) out_words[i] = '0;
    end
    acc_a = '0;
    prev_b = '0;
    round_c = '0;
    foreach (mixer[k]) mixer[k] = irg_pkg::GOLDEN;
    for (int i = 0; i < 4; i++) churn();
    for (int i = 0; i < 256; i += 8) begin
      for (int k = 0; k < 8; k++) mixer[k] += out_words[i + k];
      churn();
      for (int k = 0; k < 8; k++) mix_mem[i + k] = mixer[k];
    end
    for (int i = 0; i < 256; i += 8) begin
      for (int k = 0; k < 8; k++) mixer[k] += mix_mem[i + k];
      churn();
      for (int k = 0; k < 8; k++) mix_mem[i + k] = mixer[k];
    end
    refill();
    out_pos = 9'd256;
    seed_ok = (len >= 16);
  endfunction

  function bit [31:0] pull_word();
    bit [31:0] w;
    if (out_pos > 255) refill();
    w = out_words[out_pos[7:0]];
    out_pos = out_pos + 9'd1;
    return w;
  endfunction

  // Notes an accepted input transfer and queues its expected result.
  function void note_item(irg_pkg::item_t it);
    irg_pkg::result_t exp_res;
    bit [31:0] floor_val;
    bit [31:0] w;
    exp_res = '0;
    case (it.req_type)
      irg_pkg::REQ_SEED: out_words[it.seed_index] = it.seed_word;
      irg_pkg::REQ_INIT: seed_state(it.seed_length);
      irg_pkg::REQ_DRAW: begin
        exp_res.value = pull_word();
        exp_res.value_valid = 1'b1;
      end
      default: begin
        exp_res.value_valid = 1'b1;
        if (it.bound > 1) begin
          floor_val = (32'd0 - it.bound) % it.bound;
          do w = pull_word(); while (w < floor_val);
          exp_res.value = w % it.bound;
        end
      end
    endcase
    exp_res.seeded = seed_ok;
    pending_results.push_back(exp_res);
  endfunction

  // Compares a result transfer with the oldest expectation.
  function void check_result(irg_pkg::result_t got);
    irg_pkg::result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("unexpected result: value %h", got.value);
      errors++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (got.value !== exp_res.value) begin
      $error("value: expected %h, actual %h", exp_res.value, got.value);
      errors++;
    end
    if (got.value_valid !== exp_res.value_valid) begin
      $error("value_valid: expected %b, actual %b", exp_res.value_valid, got.value_valid);
      errors++;
    end
    if (got.seeded !== exp_res.seeded) begin
      $error("seeded: expected %b, actual %b", exp_res.seeded, got.seeded);
      errors++;
    end
  endfunction
endclass

module tb;
  import irg_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;
  int      idle_pct = 0;
  isaac_scoreboard board = new();

  isaac_random_generator dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  // Every result transfer is checked at the edge that ends its strobe.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // Offers one item, waits for the transfer, then maybe idles.
  task automatic send(input item_t it);
    int gap;
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(it);
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic item_t noise_item(logic [1:0] kind);
    item_t it;
    it.req_type = kind;
    it.seed_index = 8'($urandom_range(0, 255));
    it.seed_word = $urandom;
    it.seed_length = 11'($urandom_range(0, 2047));
    case ($urandom_range(0, 3))
      0: it.bound = $urandom_range(0, 300);
      1: it.bound = 32'h8000_0000 + $urandom_range(0, 5);
      default: it.bound = $urandom;
    endcase
    return it;
  endfunction

  function automatic item_t make_item(logic [1:0] kind, logic [7:0] idx, logic [31:0] word,
                                      logic [10:0] len, logic [31:0] n);
    item_t it;
    it.req_type = kind;
    it.seed_index = idx;
    it.seed_word = word;
    it.seed_length = len;
    it.bound = n;
    return it;
  endfunction

  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int pick;
    int cnt;
    int seeds;
    bit paused;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: draws on the reset state, small and extreme bounds, seeds and inits.
    send(make_item(REQ_DRAW, 8'd0, 32'd0, 11'd0, 32'd0));
    send(make_item(REQ_BOUNDED, 8'd0, 32'd0, 11'd0, 32'd0));
    send(make_item(REQ_BOUNDED, 8'd0, 32'd0, 11'd0, 32'd1));
    send(make_item(REQ_BOUNDED, 8'd0, 32'd0, 11'd0, 32'd2));
    send(make_item(REQ_BOUNDED, 8'd0, 32'd0, 11'd0, 32'hffff_ffff));
    send(make_item(REQ_BOUNDED, 8'd0, 32'd0, 11'd0, 32'h8000_0001));
    send(make_item(REQ_SEED, 8'd0, 32'hffff_ffff, 11'd0, 32'd0));
    send(make_item(REQ_SEED, 8'd255, 32'd0, 11'd0, 32'd0));
    send(make_item(REQ_DRAW, 8'd0, 32'd0, 11'd0, 32'd0));
    send(make_item(REQ_INIT, 8'd0, 32'd0, 11'd15, 32'd0));
    send(make_item(REQ_DRAW, 8'd0, 32'd0, 11'd0, 32'd0));
    send(make_item(REQ_SEED, 8'd7, 32'h1234_5678, 11'd0, 32'd0));
    send(make_item(REQ_INIT, 8'd0, 32'd0, 11'd16, 32'd0));
    send(make_item(REQ_DRAW, 8'd0, 32'd0, 11'd0, 32'd0));
    send(make_item(REQ_INIT, 8'd0, 32'd0, 11'd2047, 32'd0));
    send(make_item(REQ_BOUNDED, 8'd0, 32'd0, 11'd0, 32'd10));
    send(make_item(REQ_INIT, 8'd0, 32'd0, 11'd1024, 32'd0));
    send(make_item(REQ_INIT, 8'd0, 32'd0, 11'd0, 32'd0));
    send(make_item(REQ_DRAW, 8'd0, 32'd0, 11'd0, 32'd0));

    // Random: three idling phases, seeding sequences mixed with draws.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 22 : (ph == 1) ? 55 : 0;
      cnt = 0;
      while (cnt < 640) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          seeds = $urandom_range(1, 12);
          for (int k = 0; k < seeds; k++) send(noise_item(REQ_SEED));
          send(noise_item(REQ_INIT));
          cnt += seeds;
        end else if (pick < 55) begin
          send(noise_item(REQ_DRAW));
        end else if (pick < 85) begin
          send(noise_item(REQ_BOUNDED));
        end else if (pick < 98) begin
          send(noise_item(REQ_SEED));
        end else begin
          send(noise_item(REQ_INIT));
        end
        cnt++;
        if (ph == 1 && cnt >= 300 && !paused) begin
          // Hold off until every outstanding result has arrived.
          paused = 1'b1;
          start <= 1'b0;
          while (board.pending_results.size() != 0) @(posedge clk);
        end
      end
    end
    start <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+design
design/irg_pkg.sv
design/irg_div.sv
design/irg_datapath.sv
design/irg_ctrl.sv
design/isaac_random_generator.sv
design/irg_checker.sv
tb/tb.sv
